// ===== rtl/assert_macros.svh =====
// Assertion helpers for the clock unit. Every check samples on the rising
// edge of clk_i and is held off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every clock edge outside reset.
`define BSTOD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks that a property holds in the cycle after a trigger.
`define BSTOD_ASSERT_NEXT(label, trig, prop, msg) \
  `BSTOD_ASSERT(label, (trig) |=> (prop), msg)

`endif

// ===== rtl/bstod_pkg.sv =====
package bstod_pkg;

  // Number of multiplex phases; the counter runs 0 to PHASE_COUNT-1.
  localparam int PHASE_COUNT = 8;
  // The counter is never narrower than the 3-bit phase output.
  localparam int PhaseW = (PHASE_COUNT > 8) ? $clog2(PHASE_COUNT) : 3;

  localparam int LimitW = 8;
  localparam int SecW   = 6;
  localparam int MinW   = 7;
  localparam int HourW  = 5;

  localparam logic [LimitW-1:0] LIMIT_RESET = LimitW'(100);
  localparam logic [PhaseW-1:0] PHASE_LAST  = PhaseW'(PHASE_COUNT - 1);
  localparam logic [SecW-1:0]   SEC_WRAP    = SecW'(60);
  localparam logic [MinW-1:0]   MIN_WRAP    = MinW'(60);
  localparam logic [MinW-1:0]   MIN_TEN     = MinW'(10);
  localparam logic [HourW-1:0]  HOUR_WRAP   = HourW'(24);

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [LimitW-1:0] prescale;
    logic [SecW-1:0]   sec;
    logic [MinW-1:0]   min;
    logic [HourW-1:0]  hour;
    logic              lock;
  } clk_state_t;

  typedef struct packed {
    logic hour;
    logic min_ten;
    logic min_one;
  } buttons_t;

endpackage

// ===== rtl/button_set_time_of_day_clock_unit.sv =====
// A tick beat passes from the input register into the clock state registers.
// Throughput: one tick per cycle unless out_stall_i holds back a waiting result;
// the input register feeds the tick logic, whose result loads the clock state
// registers that drive the outputs.
// Reset: rst_ni clears the clock state, the lock and both valid flags and
// sets limit_q to 100; it acts at once, without a clock.
module button_set_time_of_day_clock_unit import bstod_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [LimitW-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              btn_hour_i,
  input  logic              btn_min_ten_i,
  input  logic              btn_min_one_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [HourW-1:0]  hours_o,
  output logic [5:0]        minutes_out_o,
  output logic [SecW-1:0]   seconds_out_o,
  output logic [2:0]        phase_o
);

  `include "assert_macros.svh"

  // The limit register. Writes must arrive only while the unit is idle; the
  // block does not enforce this, and the port can always take them.
  logic [LimitW-1:0] limit_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // Input register. It holds one tick beat; it moves on into the result
  // stage whenever that stage is empty or its beat is being taken.
  logic     s1_valid_q;
  buttons_t s1_btn_q;
  logic     res_valid_q;
  logic     res_load;
  logic     s1_load;

  assign res_load   = s1_valid_q && (!res_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !res_load;
  assign s1_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load || res_load) begin
      s1_valid_q <= s1_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_btn_q <= '{hour: btn_hour_i, min_ten: btn_min_ten_i, min_one: btn_min_one_i};
    end
  end

  // Clock state. It changes only when a tick beat enters the result stage,
  // so while a result waits the state registers double as the result
  // register and the outputs hold.
  clk_state_t state_q, state_d;

  bstod_tick u_tick (
    .state_i (state_q),
    .btn_i   (s1_btn_q),
    .limit_i (limit_q),
    .state_o (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (res_load) begin
        state_q <= state_d;
      end
      if (res_load || !out_stall_i) begin
        res_valid_q <= res_load;
      end
    end
  end

  assign out_valid_o   = res_valid_q;
  assign hours_o       = state_q.hour;
  assign minutes_out_o = state_q.min[5:0];
  assign seconds_out_o = state_q.sec;
  assign phase_o       = state_q.phase[2:0];

  // Terms used by the checks below.
  logic              phase_mid;
  logic [PhaseW-1:0] phase_inc;
  logic              btn_free;
  logic              time_ok;

  assign phase_mid = res_load && (state_q.phase != PHASE_LAST);
  assign phase_inc = state_q.phase + PhaseW'(1);
  assign btn_free  = res_load && (s1_btn_q == '0);
  assign time_ok   = (state_q.hour < HOUR_WRAP) && (state_q.min < MIN_WRAP)
                  && (state_q.sec < SEC_WRAP);

  // The clock state moves only with a tick.
  `BSTOD_ASSERT_NEXT(a_state_hold, !res_load, $stable(state_q), "state moved without a tick")
  // The phase steps by one per tick while below its last value.
  `BSTOD_ASSERT_NEXT(a_phase_step, phase_mid, state_q.phase == $past(phase_inc), "phase skipped")
  // A tick with no button held releases the lock.
  `BSTOD_ASSERT_NEXT(a_lock_release, btn_free, !state_q.lock, "lock held after release")
  // Time of day stays in range.
  `BSTOD_ASSERT(a_time_range, time_ok, "time of day out of range")

endmodule

// ===== rtl/bstod_tick.sv =====
module bstod_tick import bstod_pkg::*; (
  input  clk_state_t        state_i,
  input  buttons_t          btn_i,
  input  logic [LimitW-1:0] limit_i,
  output clk_state_t        state_o
);

  logic              any_btn;
  logic              add_ten, add_one, add_hour;
  logic [LimitW-1:0] pre_inc;
  logic              sec_tick, sec_carry, min_carry;
  logic [SecW-1:0]   sec_inc;
  logic [MinW-1:0]   min_inc;
  logic [HourW-1:0]  hour_inc;

  always_comb begin
    state_o = state_i;

    state_o.phase = (state_i.phase == PHASE_LAST) ? '0 : state_i.phase + PhaseW'(1);

    // Only one button acts per press; the lock follows whether any is held.
    any_btn  = btn_i.min_ten | btn_i.min_one | btn_i.hour;
    add_ten  = !state_i.lock && btn_i.min_ten;
    add_one  = !state_i.lock && !btn_i.min_ten && btn_i.min_one;
    add_hour = !state_i.lock && !btn_i.min_ten && !btn_i.min_one && btn_i.hour;
    state_o.lock = any_btn;

    pre_inc  = (state_o.phase == PHASE_LAST) ? state_i.prescale + LimitW'(1)
                                             : state_i.prescale;
    sec_tick = (pre_inc == limit_i);
    state_o.prescale = sec_tick ? '0 : pre_inc;

    sec_inc   = state_i.sec + SecW'(sec_tick);
    sec_carry = (sec_inc >= SEC_WRAP);
    state_o.sec = sec_carry ? '0 : sec_inc;

    min_inc = state_i.min + MinW'(add_one) + (add_ten ? MIN_TEN : '0) + MinW'(sec_carry);
    min_carry = (min_inc >= MIN_WRAP);
    state_o.min = min_carry ? '0 : min_inc;

    hour_inc = state_i.hour + HourW'(add_hour) + HourW'(min_carry);
    state_o.hour = (hour_inc >= HOUR_WRAP) ? '0 : hour_inc;
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import bstod_pkg::*;

  // Button codes, packed in the order {hour, min_ten, min_one}.
  localparam buttons_t BTN_NONE = 3'b000;
  localparam buttons_t BTN_HOUR = 3'b100;
  localparam buttons_t BTN_TEN  = 3'b010;
  localparam buttons_t BTN_ONE  = 3'b001;

  // The run is cut off here.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // One displayed time of day, as it leaves the block.
  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [2:0] phase;
  } clock_time_t;

  // Tracks the clock state beside the block. Every accepted tick beat
  // produces exactly one expected time, and results come back in order.
  class clock_scoreboard;
    logic [LimitW-1:0] limit     = LIMIT_RESET;
    logic [PhaseW-1:0] phase_cnt = '0;
    logic [LimitW-1:0] presc_cnt = '0;
    logic [SecW-1:0]   sec_cnt   = '0;
    logic [MinW-1:0]   min_cnt   = '0;
    logic [HourW-1:0]  hour_cnt  = '0;
    logic              locked    = 1'b0;
    clock_time_t       expected_times[$];
    int unsigned       errors    = 0;
    int unsigned       checked   = 0;
    int unsigned       midnights = 0;

    function void set_limit(logic [LimitW-1:0] value);
      limit = value;
    endfunction

    // Advances the clock by one tick and queues the time it should show.
    function void note_tick(buttons_t b);
      logic        add_hour;
      logic        add_ten;
      logic        add_one;
      clock_time_t t;
      add_hour = 1'b0;
      add_ten  = 1'b0;
      add_one  = 1'b0;

      if (phase_cnt == PHASE_LAST) phase_cnt = '0;
      else phase_cnt = phase_cnt + 1'b1;

      // Only the first button of a press acts; ten minutes wins over one
      // minute, which wins over the hour button.
      if (!locked) begin
        if (b.min_ten) begin
          add_ten = 1'b1;
          locked  = 1'b1;
        end else if (b.min_one) begin
          add_one = 1'b1;
          locked  = 1'b1;
        end else if (b.hour) begin
          add_hour = 1'b1;
          locked   = 1'b1;
        end
      end
      if (b == BTN_NONE) locked = 1'b0;

      // Plain equality: a limit below a running count lets the
      // prescaler wrap through 255 first, and a limit of zero adds a
      // second on every tick while the prescaler sits at zero.
      if (phase_cnt == PHASE_LAST) presc_cnt = presc_cnt + 1'b1;
      if (presc_cnt == limit) begin
        sec_cnt   = sec_cnt + 1'b1;
        presc_cnt = '0;
      end

      if (add_one) min_cnt = min_cnt + 1'b1;
      if (add_ten) min_cnt = min_cnt + MIN_TEN;
      if (sec_cnt >= SEC_WRAP) begin
        min_cnt = min_cnt + 1'b1;
        sec_cnt = '0;
      end

      // Minutes past 59 clear to zero rather than keeping the remainder.
      if (add_hour) hour_cnt = hour_cnt + 1'b1;
      if (min_cnt >= MIN_WRAP) begin
        hour_cnt = hour_cnt + 1'b1;
        min_cnt  = '0;
      end
      if (hour_cnt >= HOUR_WRAP) begin
        hour_cnt = '0;
        midnights++;
      end

      t.hours   = hour_cnt;
      t.minutes = min_cnt[5:0];
      t.seconds = sec_cnt;
      t.phase   = phase_cnt[2:0];
      expected_times.push_back(t);
    endfunction

    // Compares one result beat against the oldest expected time.
    function void check_time(clock_time_t got);
      clock_time_t want;
      if (expected_times.size() == 0) begin
        $error("result beat with nothing expected: %0d:%0d:%0d phase %0d",
               got.hours, got.minutes, got.seconds, got.phase);
        errors++;
        return;
      end
      want = expected_times.pop_front();
      checked++;
      if (got.hours !== want.hours) begin
        $error("hours: expected %0d, actual %0d", want.hours, got.hours);
        errors++;
      end
      if (got.minutes !== want.minutes) begin
        $error("minutes_out: expected %0d, actual %0d", want.minutes, got.minutes);
        errors++;
      end
      if (got.seconds !== want.seconds) begin
        $error("seconds_out: expected %0d, actual %0d", want.seconds, got.seconds);
        errors++;
      end
      if (got.phase !== want.phase) begin
        $error("phase: expected %0d, actual %0d", want.phase, got.phase);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_valid_i   = 1'b0;
  logic              cfg_ready_o;
  logic [LimitW-1:0] cfg_data_i    = '0;
  logic              in_valid_i    = 1'b0;
  logic              in_stall_o;
  logic              btn_hour_i    = 1'b0;
  logic              btn_min_ten_i = 1'b0;
  logic              btn_min_one_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i   = 1'b0;
  logic [HourW-1:0]  hours_o;
  logic [5:0]        minutes_out_o;
  logic [SecW-1:0]   seconds_out_o;
  logic [2:0]        phase_o;

  clock_scoreboard sb;
  // While set, neither side inserts gaps, giving back-to-back stretches.
  logic            quiet         = 1'b0;
  int unsigned     cycle_count   = 0;
  int unsigned     stall_left    = 0;
  int unsigned     ticks_sent    = 0;
  int unsigned     limits_set    = 0;

  button_set_time_of_day_clock_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .btn_hour_i    (btn_hour_i),
    .btn_min_ten_i (btn_min_ten_i),
    .btn_min_one_i (btn_min_one_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .hours_o       (hours_o),
    .minutes_out_o (minutes_out_o),
    .seconds_out_o (seconds_out_o),
    .phase_o       (phase_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (quiet || r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Receiver side: stall for random stretches. All outputs are sampled
  // before this edge's updates land, so there is no race with the block.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, sb.expected_times.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      stall_left  <= pick_gap();
      out_stall_i <= 1'b0;
    end
  end

  // A result beat is taken at every edge with valid high and stall low.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_time('{hours_o, minutes_out_o, seconds_out_o, phase_o});
  end

  // Sends one tick beat, after a random gap, and notes it once accepted.
  task automatic send_tick(buttons_t b);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    btn_hour_i    <= b.hour;
    btn_min_ten_i <= b.min_ten;
    btn_min_one_i <= b.min_one;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_tick(b);
    ticks_sent++;
  endtask

  // Holds off new ticks until every expected result has come back, then
  // lets the two-stage pipeline settle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.expected_times.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // The limit may only change while the block is idle.
  task automatic write_limit(logic [LimitW-1:0] value);
    wait_drained();
    cfg_data_i  <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_limit(value);
    limits_set++;
    repeat (2) @(posedge clk_i);
  endtask

  // One button press: held for a few ticks, where the content may change
  // while locked, and usually released. A press without release runs into
  // the next one. Ten-minute presses are favored so the hours roll over.
  task automatic press_sequence();
    buttons_t b;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) b = BTN_TEN;
    else if (r < 60) b = BTN_ONE;
    else if (r < 80) b = BTN_HOUR;
    else b = buttons_t'($urandom_range(7, 1));
    send_tick(b);
    repeat ($urandom_range(2, 0)) begin
      if ($urandom_range(1)) b = buttons_t'($urandom_range(7, 1));
      send_tick(b);
    end
    if ($urandom_range(3) != 0) begin
      repeat ($urandom_range(2, 1)) send_tick(BTN_NONE);
    end
    // Idle ticks let the seconds run between presses.
    repeat ($urandom_range(6, 0)) send_tick(BTN_NONE);
  endtask

  // Directed opening: each button alone, every priority pair, changes while
  // locked, and the release that clears the lock.
  localparam buttons_t OPENING[20] = '{
    BTN_NONE, BTN_TEN, BTN_TEN, BTN_NONE, BTN_ONE, BTN_NONE, BTN_HOUR, BTN_NONE,
    BTN_TEN | BTN_ONE | BTN_HOUR, BTN_ONE, BTN_HOUR | BTN_ONE, BTN_NONE,
    BTN_ONE | BTN_HOUR, BTN_TEN, BTN_NONE, BTN_HOUR | BTN_TEN, BTN_HOUR, BTN_NONE,
    BTN_TEN | BTN_ONE, BTN_NONE
  };

  // Random phases run with these limits, in this order. Fast settings come
  // first; zero and the top value follow, and the last write may fall below a
  // running prescaler count, which makes it run up toward the wrap.
  localparam int unsigned PHASES = 6;
  localparam int unsigned PHASE_TICKS[PHASES] = '{300, 300, 250, 200, 250, 230};

  initial begin
    logic [LimitW-1:0] limits[PHASES];
    int unsigned       start;
    bit                paused;
    sb = new();
    limits = '{8'd1, 8'd3, LimitW'($urandom_range(6, 2)), 8'd0, 8'd255, 8'd2};
    paused = 1'b0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // The opening runs at the reset value of the limit.
    foreach (OPENING[i]) send_tick(OPENING[i]);

    for (int p = 0; p < PHASES; p++) begin
      write_limit(limits[p]);
      start = ticks_sent;
      while (ticks_sent - start < PHASE_TICKS[p]) begin
        if ((ticks_sent - start) % 64 == 0) quiet = ($urandom_range(3) == 0);
        // Once, the sender stops mid-phase and lets the results run dry.
        if (!paused && ticks_sent - start >= PHASE_TICKS[p] / 2) begin
          wait_drained();
          paused = 1'b1;
        end
        if ($urandom_range(99) < 80) begin
          press_sequence();
        end else begin
          repeat ($urandom_range(4, 1)) send_tick(buttons_t'($urandom_range(7, 0)));
        end
      end
    end

    quiet = 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d tick beats and checked %0d results over %0d limit settings.",
             ticks_sent, sb.checked, limits_set + 1);
    $display("The clock rolled over midnight %0d times; %0d field mismatches.",
             sb.midnights, sb.errors);
    if (sb.errors == 0 && sb.expected_times.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== button_set_time_of_day_clock_unit.f =====
+incdir+rtl
rtl/bstod_pkg.sv
rtl/bstod_tick.sv
rtl/button_set_time_of_day_clock_unit.sv
sim/tb.sv
